// File: hw/rtl/numpt_pkg.sv
// ----------------------------------------------------------------------------
// numpt_pkg
// Shared constants for the numeric parameter tokenizer: character codes,
// field widths and default parameter values.
// ----------------------------------------------------------------------------
package numpt_pkg;

  // Field widths
  localparam int CHAR_W        = 8;
  localparam int VALUE_W       = 31;
  localparam int PARAM_COUNT_W = 5;

  // Default parameter values
  localparam int DEF_MAX_PARAMS   = 16;
  localparam int DEF_TOKEN_BUFFER = 16;

  // Saturation ceiling of the accumulators
  localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

endpackage

// File: hw/rtl/numeric_parameter_tokenizer.sv
// ----------------------------------------------------------------------------
// numeric_parameter_tokenizer
// Splits argument text into whitespace-separated integer tokens, detects hex
// tokens, and reports each saturated value and the end of the line.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  in      | in_valid / in_ready   | char_byte, start_of_line
//  out     | out_valid / out_ready | value, has_value, line_done, param_count
//
//  One byte per cycle sustained while the output is not stalled. A byte lands
//  in the input register, then one pass of classify / multiply-add / saturate
//  updates the token state and, when a token or the line ends, loads the
//  result register, from which the result of the byte is offered.
//  After rst the block waits for a byte with start_of_line set.
//  A stalled output holds only bytes that produce a result; other bytes keep
//  flowing through while the result register is full.
//
module numeric_parameter_tokenizer #(
  parameter int MAX_PARAMS   = numpt_pkg::DEF_MAX_PARAMS,
  parameter int TOKEN_BUFFER = numpt_pkg::DEF_TOKEN_BUFFER
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [numpt_pkg::CHAR_W-1:0]        char_byte,
  input  logic                                start_of_line,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [numpt_pkg::VALUE_W-1:0]       value,
  output logic                                has_value,
  output logic                                line_done,
  output logic [numpt_pkg::PARAM_COUNT_W-1:0] param_count
);
  import numpt_pkg::*;

  localparam int VF_W = $clog2(MAX_PARAMS + 1);
  localparam int KD_W = $clog2(TOKEN_BUFFER);
  localparam logic [KD_W-1:0] KD_LIMIT = KD_W'(TOKEN_BUFFER - 1);
  localparam logic [VF_W-1:0] VF_LIMIT = VF_W'(MAX_PARAMS);
  localparam int ACC_W = VALUE_W + 4;

  // Input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_sol;

  // Token and line state
  logic [VALUE_W-1:0] decimal_total, decimal_total_next;
  logic [VALUE_W-1:0] hex_total, hex_total_next;
  logic [KD_W-1:0]    kept_digits, kept_digits_next;
  logic               hex_seen, hex_seen_next;
  logic [VF_W-1:0]    values_found, values_found_next;
  logic               line_finished, line_finished_next;

  // Pass signals
  logic [VALUE_W-1:0] dec_base, hex_base;
  logic [KD_W-1:0]    kd_base;
  logic               hex_base_seen;
  logic [VF_W-1:0]    vf_base;
  logic               lf_base;
  logic [CHAR_W-1:0]  c_low;
  logic               is_sep, is_dec, is_let, is_x;
  logic [3:0]         digit;
  logic [ACC_W-1:0]   dec_mac, hex_mac;
  logic [VALUE_W-1:0] dec_sat, hex_sat;
  logic               emit, emit_has, emit_done;
  logic [VALUE_W-1:0] emit_value;
  logic [VF_W+PARAM_COUNT_W-1:0] count_ext;
  logic               slot_free, s1_fire;

  // Handshake: drain the input register when its byte can complete
  assign slot_free = !out_valid || out_ready;
  assign s1_fire   = s1_valid && (!emit || slot_free);
  assign in_ready  = !s1_valid || s1_fire;

  // Hold the byte in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char <= char_byte;
      s1_sol  <= start_of_line;
    end
  end

  // Classify the byte and form both saturating accumulators
  always_comb begin
    c_low  = s1_char | CASE_BIT;
    is_sep = (s1_char <= CH_SPACE);
    is_dec = (s1_char >= CH_0) && (s1_char <= CH_9);
    is_let = (c_low >= CH_A_LO) && (c_low <= CH_F_LO);
    is_x   = (c_low == CH_X_LO);
    if (is_dec) begin
      digit = 4'(s1_char - CH_0);
    end else begin
      digit = 4'(c_low - CH_A_LO + 8'd10);
    end

    // A start of line clears everything before this byte is processed
    dec_base      = s1_sol ? '0 : decimal_total;
    hex_base      = s1_sol ? '0 : hex_total;
    kd_base       = s1_sol ? '0 : kept_digits;
    hex_base_seen = s1_sol ? 1'b0 : hex_seen;
    vf_base       = s1_sol ? '0 : values_found;
    lf_base       = s1_sol ? 1'b0 : line_finished;

    // acc * 10 + d and acc * 16 + d
    dec_mac = ({4'b0, dec_base} << 3) + ({4'b0, dec_base} << 1) + ACC_W'(digit);
    hex_mac = {hex_base, digit};
    dec_sat = (dec_mac > ACC_W'(VALUE_MAX)) ? VALUE_MAX : dec_mac[VALUE_W-1:0];
    hex_sat = (|hex_mac[ACC_W-1:VALUE_W]) ? VALUE_MAX : hex_mac[VALUE_W-1:0];
  end

  // Next state and result
  always_comb begin
    decimal_total_next = dec_base;
    hex_total_next     = hex_base;
    kept_digits_next   = kd_base;
    hex_seen_next      = hex_base_seen;
    values_found_next  = vf_base;
    line_finished_next = lf_base;
    emit_has   = 1'b0;
    emit_done  = 1'b0;
    emit_value = '0;

    if (!lf_base) begin
      if (is_sep) begin
        // Close the token
        if (kd_base != '0) begin
          emit_has          = 1'b1;
          emit_value        = hex_base_seen ? hex_base : dec_base;
          values_found_next = vf_base + VF_W'(1);
        end
        emit_done          = (s1_char == CH_NUL) || (values_found_next >= VF_LIMIT);
        decimal_total_next = '0;
        hex_total_next     = '0;
        kept_digits_next   = '0;
        hex_seen_next      = 1'b0;
        line_finished_next = emit_done;
      end else if (kd_base < KD_LIMIT) begin
        // Keep a digit, switch to hex, or restart on x
        if (is_dec) begin
          decimal_total_next = dec_sat;
          hex_total_next     = hex_sat;
          kept_digits_next   = kd_base + KD_W'(1);
        end else if (is_let) begin
          hex_total_next   = hex_sat;
          kept_digits_next = kd_base + KD_W'(1);
          hex_seen_next    = 1'b1;
        end else if (is_x) begin
          decimal_total_next = '0;
          hex_total_next     = '0;
          kept_digits_next   = '0;
          hex_seen_next      = 1'b1;
        end
      end
    end
    emit = emit_has || emit_done;
  end

  // Advance the token state
  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_total <= '0;
      hex_total     <= '0;
      kept_digits   <= '0;
      hex_seen      <= 1'b0;
      values_found  <= '0;
      line_finished <= 1'b1;
    end else if (s1_fire) begin
      decimal_total <= decimal_total_next;
      hex_total     <= hex_total_next;
      kept_digits   <= kept_digits_next;
      hex_seen      <= hex_seen_next;
      values_found  <= values_found_next;
      line_finished <= line_finished_next;
    end
  end

  // Load the result register; drop it once taken
  assign count_ext = {{PARAM_COUNT_W{1'b0}}, values_found_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_fire && emit) begin
      value       <= emit_value;
      has_value   <= emit_has;
      line_done   <= emit_done;
      param_count <= count_ext[PARAM_COUNT_W-1:0];
    end
  end

  // Checks
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_value || line_done))
    else $error("result without a value or line end");

  a_empty_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_value) |-> (value == '0))
    else $error("nonzero value with has_value low");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    values_found <= VF_LIMIT)
    else $error("value count beyond limit");

  a_limit_ends_line: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !line_finished_next && !lf_base) |-> (values_found_next < VF_LIMIT))
    else $error("line kept open at the value limit");

endmodule

// File: tb/numeric_parameter_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// numeric_parameter_tokenizer_checker
// Watches both channels of the tokenizer. Each accepted byte updates a model
// of the token state and may queue one expected result. Each result taken
// from the block is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module numeric_parameter_tokenizer_checker #(
  parameter int MAX_PARAMS   = numpt_pkg::DEF_MAX_PARAMS,
  parameter int TOKEN_BUFFER = numpt_pkg::DEF_TOKEN_BUFFER
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [numpt_pkg::CHAR_W-1:0]        char_byte,
  input  logic                                start_of_line,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [numpt_pkg::VALUE_W-1:0]       value,
  input  logic                                has_value,
  input  logic                                line_done,
  input  logic [numpt_pkg::PARAM_COUNT_W-1:0] param_count,
  output int                                  mismatch_total,
  output int                                  results_pending,
  output int                                  bytes_taken
);
  timeunit 1ns;
  timeprecision 1ps;
  import numpt_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0]       value;
    logic                     has_value;
    logic                     line_done;
    logic [PARAM_COUNT_W-1:0] param_count;
  } token_result_t;

  // Model of the token state
  logic [VALUE_W-1:0] dec_acc;
  logic [VALUE_W-1:0] hex_acc;
  int                 digit_count;
  bit                 hex_mode;
  int                 param_total;
  bit                 line_closed;

  token_result_t token_results_q[$];
  int            fail_n;
  int            taken_n;

  function automatic logic [VALUE_W-1:0] mac_saturate(logic [VALUE_W-1:0] acc,
                                                     int unsigned base,
                                                     int unsigned digit);
    longint unsigned t;
    t = acc;
    t = t * base + digit;
    if (t > VALUE_MAX) return VALUE_MAX;
    return t[VALUE_W-1:0];
  endfunction

  function automatic void clear_token();
    dec_acc     = '0;
    hex_acc     = '0;
    digit_count = 0;
    hex_mode    = 1'b0;
  endfunction

  // Advance the model by one byte; queue a result when a token or the line ends
  function automatic void tokenize_byte(logic [CHAR_W-1:0] ch, logic sol);
    token_result_t r;
    logic [CHAR_W-1:0] folded;
    bit done;
    r = '0;
    folded = ch | CASE_BIT;
    if (sol) begin
      clear_token();
      param_total = 0;
      line_closed = 1'b0;
    end
    if (line_closed) return;

    if (ch <= CH_SPACE) begin
      if (digit_count > 0) begin
        r.value     = hex_mode ? hex_acc : dec_acc;
        r.has_value = 1'b1;
        param_total++;
      end
      done = (ch == CH_NUL) || (param_total >= MAX_PARAMS);
      clear_token();
      if (done) line_closed = 1'b1;
      if (r.has_value || done) begin
        r.line_done   = done;
        r.param_count = param_total[PARAM_COUNT_W-1:0];
        token_results_q.push_back(r);
      end
    end else if (digit_count < TOKEN_BUFFER - 1) begin
      if (ch >= CH_0 && ch <= CH_9) begin
        dec_acc = mac_saturate(dec_acc, 10, ch - CH_0);
        hex_acc = mac_saturate(hex_acc, 16, ch - CH_0);
        digit_count++;
      end else if (folded >= CH_A_LO && folded <= CH_F_LO) begin
        hex_acc  = mac_saturate(hex_acc, 16, folded - CH_A_LO + 10);
        hex_mode = 1'b1;
        digit_count++;
      end else if (folded == CH_X_LO) begin
        dec_acc     = '0;
        hex_acc     = '0;
        digit_count = 0;
        hex_mode    = 1'b1;
      end
    end
  endfunction

  // Predict on accepted bytes, compare on accepted results
  always @(posedge clk) begin
    token_result_t want;
    if (rst) begin
      clear_token();
      param_total = 0;
      line_closed = 1'b1;
      token_results_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        tokenize_byte(char_byte, start_of_line);
        taken_n++;
      end
      if (out_valid && out_ready) begin
        if (token_results_q.size() == 0) begin
          $error("unexpected result: value %0d has_value %0b line_done %0b param_count %0d",
                 value, has_value, line_done, param_count);
          fail_n++;
        end else begin
          want = token_results_q.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            fail_n++;
          end
          if (has_value !== want.has_value) begin
            $error("has_value: expected %0b, got %0b", want.has_value, has_value);
            fail_n++;
          end
          if (line_done !== want.line_done) begin
            $error("line_done: expected %0b, got %0b", want.line_done, line_done);
            fail_n++;
          end
          if (param_count !== want.param_count) begin
            $error("param_count: expected %0d, got %0d", want.param_count, param_count);
            fail_n++;
          end
        end
      end
    end
    mismatch_total  <= fail_n;
    results_pending <= token_results_q.size();
    bytes_taken     <= taken_n;
  end

endmodule

// File: tb/numeric_parameter_tokenizer_test.sv
// ----------------------------------------------------------------------------
// numeric_parameter_tokenizer_test
// Feeds argument text to the tokenizer: a directed set of corner cases, then
// random lines built from decimal, hex, overlong and noise tokens, under
// three idling patterns, the last with a long output stall. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module numeric_parameter_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import numpt_pkg::*;

  localparam int MAX_PARAMS    = DEF_MAX_PARAMS;
  localparam int TOKEN_BUFFER  = DEF_TOKEN_BUFFER;
  localparam int PHASE_BYTES   = 535;
  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 8;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     in_valid      = 1'b0;
  logic                     in_ready;
  logic [CHAR_W-1:0]        char_byte     = '0;
  logic                     start_of_line = 1'b0;
  logic                     out_valid;
  logic                     out_ready     = 1'b0;
  logic [VALUE_W-1:0]       value;
  logic                     has_value;
  logic                     line_done;
  logic [PARAM_COUNT_W-1:0] param_count;

  int mismatch_total;
  int results_pending;
  int bytes_taken;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent    = 0;
  bit hold_req      = 1'b0;
  bit hold_seen     = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  logic [CHAR_W-1:0] line_bytes[$];

  always #5 clk = ~clk;

  numeric_parameter_tokenizer #(
    .MAX_PARAMS  (MAX_PARAMS),
    .TOKEN_BUFFER(TOKEN_BUFFER)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_byte    (char_byte),
    .start_of_line(start_of_line),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .has_value    (has_value),
    .line_done    (line_done),
    .param_count  (param_count)
  );

  numeric_parameter_tokenizer_checker #(
    .MAX_PARAMS  (MAX_PARAMS),
    .TOKEN_BUFFER(TOKEN_BUFFER)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_byte      (char_byte),
    .start_of_line  (start_of_line),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .value          (value),
    .has_value      (has_value),
    .line_done      (line_done),
    .param_count    (param_count),
    .mismatch_total (mismatch_total),
    .results_pending(results_pending),
    .bytes_taken    (bytes_taken)
  );

  // Receiver: random back-pressure, or a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic sol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    char_byte     <= ch;
    start_of_line <= sol;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_str(input string s, input logic sol);
    for (int i = 0; i < s.len(); i++) send_char(s[i], sol && (i == 0));
  endtask

  // Pause the sender until every expected result has been taken
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0 || bytes_taken != bytes_sent);
  endtask

  function automatic logic [CHAR_W-1:0] dec_char();
    return CHAR_W'(CH_0 + $urandom_range(9));
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char();
    int unsigned d;
    d = $urandom_range(15);
    if (d < 10) return CHAR_W'(CH_0 + d);
    return CHAR_W'(CH_A_LO + d - 10) ^ ($urandom_range(1) ? CASE_BIT : CH_NUL);
  endfunction

  function automatic logic [CHAR_W-1:0] x_char();
    return $urandom_range(1) ? CH_X_LO : (CH_X_LO ^ CASE_BIT);
  endfunction

  // Separator other than the line terminator
  function automatic void add_separator();
    line_bytes.push_back($urandom_range(3) == 0 ? CHAR_W'($urandom_range(1, 32)) : CH_SPACE);
  endfunction

  // Append one random token of a random kind
  function automatic void add_token();
    int n;
    case ($urandom_range(7))
      0: begin
        n = $urandom_range(1, 3);
        repeat (n) line_bytes.push_back(dec_char());
      end
      1: begin
        n = $urandom_range(4, 12);
        repeat (n) line_bytes.push_back(dec_char());
      end
      2: begin
        n = $urandom_range(1, 9);
        line_bytes.push_back(CH_0);
        line_bytes.push_back(x_char());
        repeat (n) line_bytes.push_back(hex_char());
      end
      3: begin
        n = $urandom_range(1, 9);
        repeat (n) line_bytes.push_back(hex_char());
      end
      4: begin
        n = $urandom_range(14, 20);
        repeat (n) begin
          if ($urandom_range(9) == 0) line_bytes.push_back(x_char());
          else line_bytes.push_back(hex_char());
        end
      end
      5: begin
        n = $urandom_range(1, 4);
        repeat (n) line_bytes.push_back(CHAR_W'($urandom_range(33, 255)));
      end
      6: begin
        n = $urandom_range(1, 4);
        repeat (n) line_bytes.push_back(dec_char());
        line_bytes.push_back(x_char());
        n = $urandom_range(0, 5);
        repeat (n) line_bytes.push_back(hex_char());
      end
      default: line_bytes.push_back(x_char());
    endcase
  endfunction

  // Build and send one line; start_of_line marks its first byte
  task automatic send_random_line(input bit dense);
    int tokens;
    int n;
    line_bytes.delete();
    if (dense) tokens = MAX_PARAMS + 2;
    else if ($urandom_range(9) == 0) tokens = $urandom_range(MAX_PARAMS, MAX_PARAMS + 4);
    else tokens = $urandom_range(0, 6);
    if ($urandom_range(3) == 0) add_separator();
    repeat (tokens) begin
      if (dense) line_bytes.push_back(dec_char());
      else add_token();
      add_separator();
    end
    case ($urandom_range(9))
      0, 1: ;
      2, 3: begin
        line_bytes.push_back(CH_NUL);
        n = $urandom_range(1, 3);
        repeat (n) line_bytes.push_back(CHAR_W'($urandom_range(255)));
      end
      default: line_bytes.push_back(CH_NUL);
    endcase
    foreach (line_bytes[i]) send_char(line_bytes[i], i == 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: bytes before any start, zero, hex letters, x discard,
    // high byte, empty and lone-x tokens, saturated full token, line end
    send_str("3 ", 1'b0);
    send_str("0 ", 1'b1);
    send_str("fA", 1'b0);
    send_char(8'h09, 1'b0);
    send_str("1x2", 1'b0);
    send_char(8'h80, 1'b0);
    send_str("  X ", 1'b0);
    send_str("9999999999999999x", 1'b0);
    send_char(CH_NUL, 1'b0);
    wait_results_drained();

    // Random lines under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_idle_pct = 88; end
        1: begin send_idle_pct = 88; recv_idle_pct = 20; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req <= ~hold_req;
          send_random_line(1'b1);
        end
      endcase
      for (int target = bytes_sent + PHASE_BYTES; bytes_sent < target; )
        send_random_line(1'b0);
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/numpt_pkg.sv
hw/rtl/numeric_parameter_tokenizer.sv
tb/numeric_parameter_tokenizer_checker.sv
tb/numeric_parameter_tokenizer_test.sv
